@@ hdl/i2c_master_byte_engine_macros.svh @@
// ----------------------------------------------------------------------------
// I2C master byte engine assertion macros
// Concurrent property wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH

`ifndef SYNTH
`define I2CM_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("i2cm assertion failed");
`define I2CM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("i2cm assertion failed");
`else
`define I2CM_ASSERT_SAME(label, clk, rstn, ante, cons)
`define I2CM_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ hdl/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types, command codes and sequencer phase encoding.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;

    localparam logic       CFG_ACK_TIMEOUT = 1'b0;
    localparam logic       CFG_PHASE_TICKS = 1'b1;

    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd200;
    localparam logic [7:0] PHASE_TICKS_RST = 8'd4;

    typedef enum logic [21:0] {
        PH_IDLE    = 22'd1 << 0,
        PH_ST_A    = 22'd1 << 1,
        PH_ST_B    = 22'd1 << 2,
        PH_ST_C    = 22'd1 << 3,
        PH_SP_A    = 22'd1 << 4,
        PH_SP_B    = 22'd1 << 5,
        PH_SP_C    = 22'd1 << 6,
        PH_WR_LEAD = 22'd1 << 7,
        PH_WR_DATA = 22'd1 << 8,
        PH_WR_HIGH = 22'd1 << 9,
        PH_WR_LOW  = 22'd1 << 10,
        PH_WA_LOW  = 22'd1 << 11,
        PH_WA_HIGH = 22'd1 << 12,
        PH_WA_WAIT = 22'd1 << 13,
        PH_WA_DONE = 22'd1 << 14,
        PH_RD_LOW  = 22'd1 << 15,
        PH_RD_HIGH = 22'd1 << 16,
        PH_RD_TAIL = 22'd1 << 17,
        PH_AK_LOW  = 22'd1 << 18,
        PH_AK_SET  = 22'd1 << 19,
        PH_AK_HIGH = 22'd1 << 20,
        PH_AK_TAIL = 22'd1 << 21
    } phase_t;

    typedef struct packed {
        logic [7:0] ticks;
        logic [7:0] limit;
    } cfg_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timed_out;
        logic       ack_ok;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       sda_level;
        logic       scl_level;
    } res_t;

endpackage

@@ hdl/i2cm_cfg.sv @@
// ----------------------------------------------------------------------------
// I2C master configuration registers
// Holds acknowledge timeout and phase length; zero values act as one.
// ----------------------------------------------------------------------------
module i2cm_cfg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [7:0]    cfg_data,
    output i2cm_pkg::cfg_t cfg
);

    logic [7:0] ack_timeout_reg;
    logic [7:0] phase_ticks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_timeout_reg <= i2cm_pkg::ACK_TIMEOUT_RST;
            phase_ticks_reg <= i2cm_pkg::PHASE_TICKS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                i2cm_pkg::CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data;
                i2cm_pkg::CFG_PHASE_TICKS: phase_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.ticks = (phase_ticks_reg == 8'd0) ? 8'd1 : phase_ticks_reg;
    assign cfg.limit = (ack_timeout_reg == 8'd0) ? 8'd1 : ack_timeout_reg;

endmodule

@@ hdl/i2cm_seq.sv @@
// ----------------------------------------------------------------------------
// I2C master pin sequencer
// Phase state machine; advances one step per accepted item and produces
// the pin and status values for that item.
// ----------------------------------------------------------------------------
`include "i2c_master_byte_engine_macros.svh"

module i2cm_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  logic [2:0]     mode,
    input  logic [7:0]     write_data,
    input  logic           ack_level,
    input  logic           sda_sample,
    input  i2cm_pkg::cfg_t cfg,
    output i2cm_pkg::res_t res_next
);

    i2cm_pkg::phase_t phase_reg, phase_next, target;
    logic [2:0] cmd_reg, cmd_next;
    logic [3:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] ack_wait_reg, ack_wait_next;
    logic [7:0] tick_cnt_reg, tick_cnt_next;
    logic       ack_hold_reg, ack_hold_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       drv_reg, drv_next;
    logic       ack_ok_reg, ack_ok_next;
    logic       timed_out_reg, timed_out_next;
    logic [7:0] rx_reg, rx_next;
    logic       done_next;
    logic       enter;
    logic       fin;
    logic [7:0] ack_wait_inc;

    always_comb begin
        phase_next     = phase_reg;
        cmd_next       = cmd_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        ack_wait_next  = ack_wait_reg;
        tick_cnt_next  = tick_cnt_reg;
        ack_hold_next  = ack_hold_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        drv_next       = drv_reg;
        ack_ok_next    = ack_ok_reg;
        timed_out_next = timed_out_reg;
        rx_next        = rx_reg;
        done_next      = 1'b0;
        enter          = 1'b0;
        fin            = 1'b0;
        target         = i2cm_pkg::PH_IDLE;
        ack_wait_inc   = ack_wait_reg + 8'd1;

        if (phase_reg == i2cm_pkg::PH_IDLE) begin
            unique case (mode)
                i2cm_pkg::MODE_START: begin
                    cmd_next = mode; bit_cnt_next = 4'd0;
                    enter = 1'b1; target = i2cm_pkg::PH_ST_A;
                end
                i2cm_pkg::MODE_STOP: begin
                    cmd_next = mode; bit_cnt_next = 4'd0;
                    enter = 1'b1; target = i2cm_pkg::PH_SP_A;
                end
                i2cm_pkg::MODE_WRITE: begin
                    cmd_next = mode; bit_cnt_next = 4'd0;
                    shift_next = write_data;
                    ack_ok_next = 1'b0; timed_out_next = 1'b0;
                    enter = 1'b1; target = i2cm_pkg::PH_WR_LEAD;
                end
                i2cm_pkg::MODE_READ: begin
                    cmd_next = mode; bit_cnt_next = 4'd0;
                    shift_next = 8'd0;
                    ack_hold_next = ack_level;
                    enter = 1'b1; target = i2cm_pkg::PH_RD_LOW;
                end
                default: ;
            endcase
        end else if (phase_reg == i2cm_pkg::PH_WA_WAIT) begin
            if (!sda_sample) begin
                enter = 1'b1; target = i2cm_pkg::PH_WA_DONE;
            end else begin
                ack_wait_next = ack_wait_inc;
                if (ack_wait_inc >= cfg.limit) begin
                    enter = 1'b1; target = i2cm_pkg::PH_SP_A;
                end
            end
        end else if (tick_cnt_reg < cfg.ticks) begin
            tick_cnt_next = tick_cnt_reg + 8'd1;
        end else begin
            unique case (phase_reg)
                i2cm_pkg::PH_ST_A:    begin enter = 1'b1; target = i2cm_pkg::PH_ST_B; end
                i2cm_pkg::PH_ST_B:    begin enter = 1'b1; target = i2cm_pkg::PH_ST_C; end
                i2cm_pkg::PH_SP_A:    begin enter = 1'b1; target = i2cm_pkg::PH_SP_B; end
                i2cm_pkg::PH_SP_B:    begin enter = 1'b1; target = i2cm_pkg::PH_SP_C; end
                i2cm_pkg::PH_WR_LEAD: begin enter = 1'b1; target = i2cm_pkg::PH_WR_DATA; end
                i2cm_pkg::PH_WR_DATA: begin enter = 1'b1; target = i2cm_pkg::PH_WR_HIGH; end
                i2cm_pkg::PH_WR_HIGH: begin enter = 1'b1; target = i2cm_pkg::PH_WR_LOW; end
                i2cm_pkg::PH_WR_LOW: begin
                    shift_next   = {shift_reg[6:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg + 4'd1;
                    enter  = 1'b1;
                    target = bit_cnt_next[3] ? i2cm_pkg::PH_WA_LOW : i2cm_pkg::PH_WR_DATA;
                end
                i2cm_pkg::PH_WA_LOW:  begin enter = 1'b1; target = i2cm_pkg::PH_WA_HIGH; end
                i2cm_pkg::PH_WA_HIGH: begin enter = 1'b1; target = i2cm_pkg::PH_WA_WAIT; end
                i2cm_pkg::PH_RD_LOW:  begin enter = 1'b1; target = i2cm_pkg::PH_RD_HIGH; end
                i2cm_pkg::PH_RD_HIGH: begin
                    shift_next   = {shift_reg[6:0], sda_sample};
                    bit_cnt_next = bit_cnt_reg + 4'd1;
                    enter  = 1'b1;
                    target = bit_cnt_next[3] ? i2cm_pkg::PH_RD_TAIL : i2cm_pkg::PH_RD_LOW;
                end
                i2cm_pkg::PH_RD_TAIL: begin enter = 1'b1; target = i2cm_pkg::PH_AK_LOW; end
                i2cm_pkg::PH_AK_LOW:  begin enter = 1'b1; target = i2cm_pkg::PH_AK_SET; end
                i2cm_pkg::PH_AK_SET:  begin enter = 1'b1; target = i2cm_pkg::PH_AK_HIGH; end
                i2cm_pkg::PH_AK_HIGH: begin enter = 1'b1; target = i2cm_pkg::PH_AK_TAIL; end
                default: fin = 1'b1;
            endcase
        end

        if (fin) begin
            if (cmd_reg == i2cm_pkg::MODE_WRITE) begin
                ack_ok_next    = (phase_reg == i2cm_pkg::PH_WA_DONE);
                timed_out_next = (phase_reg != i2cm_pkg::PH_WA_DONE);
            end else if (cmd_reg == i2cm_pkg::MODE_READ) begin
                rx_next = shift_reg;
            end
            phase_next    = i2cm_pkg::PH_IDLE;
            tick_cnt_next = 8'd0;
            done_next     = 1'b1;
        end

        if (enter) begin
            phase_next    = target;
            tick_cnt_next = 8'd1;
            unique case (target)
                i2cm_pkg::PH_ST_A:    begin drv_next = 1'b1; sda_next = 1'b1; scl_next = 1'b1; end
                i2cm_pkg::PH_ST_B:    sda_next = 1'b0;
                i2cm_pkg::PH_ST_C:    scl_next = 1'b0;
                i2cm_pkg::PH_SP_A:    begin drv_next = 1'b1; sda_next = 1'b0; end
                i2cm_pkg::PH_SP_B:    scl_next = 1'b1;
                i2cm_pkg::PH_SP_C:    sda_next = 1'b1;
                i2cm_pkg::PH_WR_LEAD: begin drv_next = 1'b1; scl_next = 1'b0; end
                i2cm_pkg::PH_WR_DATA: sda_next = shift_next[7];
                i2cm_pkg::PH_WR_HIGH: scl_next = 1'b1;
                i2cm_pkg::PH_WR_LOW:  scl_next = 1'b0;
                i2cm_pkg::PH_WA_LOW:  begin drv_next = 1'b0; sda_next = 1'b1; scl_next = 1'b0; end
                i2cm_pkg::PH_WA_HIGH: scl_next = 1'b1;
                i2cm_pkg::PH_WA_WAIT: ack_wait_next = 8'd0;
                i2cm_pkg::PH_WA_DONE: scl_next = 1'b0;
                i2cm_pkg::PH_RD_LOW:  begin drv_next = 1'b0; sda_next = 1'b1; scl_next = 1'b0; end
                i2cm_pkg::PH_RD_HIGH: scl_next = 1'b1;
                i2cm_pkg::PH_RD_TAIL: scl_next = 1'b0;
                i2cm_pkg::PH_AK_LOW:  begin drv_next = 1'b1; scl_next = 1'b0; end
                i2cm_pkg::PH_AK_SET:  sda_next = ack_hold_next;
                i2cm_pkg::PH_AK_HIGH: scl_next = 1'b1;
                i2cm_pkg::PH_AK_TAIL: scl_next = 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= i2cm_pkg::PH_IDLE;
            cmd_reg       <= 3'd0;
            bit_cnt_reg   <= 4'd0;
            shift_reg     <= 8'd0;
            ack_wait_reg  <= 8'd0;
            tick_cnt_reg  <= 8'd0;
            ack_hold_reg  <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            drv_reg       <= 1'b1;
            ack_ok_reg    <= 1'b0;
            timed_out_reg <= 1'b0;
            rx_reg        <= 8'd0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            cmd_reg       <= cmd_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_reg     <= shift_next;
            ack_wait_reg  <= ack_wait_next;
            tick_cnt_reg  <= tick_cnt_next;
            ack_hold_reg  <= ack_hold_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            drv_reg       <= drv_next;
            ack_ok_reg    <= ack_ok_next;
            timed_out_reg <= timed_out_next;
            rx_reg        <= rx_next;
        end
    end

    assign res_next.scl_level = scl_next;
    assign res_next.sda_level = drv_next ? sda_next : 1'b1;
    assign res_next.sda_drive = drv_next;
    assign res_next.busy_res  = (phase_next != i2cm_pkg::PH_IDLE);
    assign res_next.done_res  = done_next;
    assign res_next.ack_ok    = ack_ok_next;
    assign res_next.timed_out = timed_out_next;
    assign res_next.read_data = rx_next;

    `I2CM_ASSERT_SAME(a_read_released, aclk, aresetn, phase_reg == i2cm_pkg::PH_RD_HIGH, !drv_reg)
    `I2CM_ASSERT_SAME(a_bit_cnt_range, aclk, aresetn, bit_cnt_reg[3], bit_cnt_reg[2:0] == 3'd0)
    `I2CM_ASSERT_NEXT(a_write_lead, aclk, aresetn, accept && phase_reg == i2cm_pkg::PH_IDLE && mode == i2cm_pkg::MODE_WRITE, phase_reg == i2cm_pkg::PH_WR_LEAD)

endmodule

@@ hdl/i2cm_out.sv @@
// ----------------------------------------------------------------------------
// I2C master result register
// Holds one result transaction and packs it onto the master stream.
// ----------------------------------------------------------------------------
module i2cm_out (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           accept,
    input  i2cm_pkg::res_t res_next,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [15:0]    m_tdata
);

    logic           m_tvalid_reg;
    i2cm_pkg::res_t res_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, res_reg};

endmodule

@@ hdl/i2c_master_byte_engine.sv @@
// A result transaction is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle while the result register can take it; the phase sequencer steps once per item.
// Input is accepted while the result register is empty or being drained.
// Reset (aresetn low, synchronous): idle phase, SCL high, SDA driven high,
// flags and read data cleared, ack_timeout 200, phase_ticks 4.
// ----------------------------------------------------------------------------
// I2C master byte engine
// Start, stop, byte write and byte read sequencing of SCL and SDA pins.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // write_data[7:0], ack_level[8], sda_sample[9], zero
    input  logic [2:0]  s_tuser,   // mode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // scl_level, sda_level, sda_drive, busy_res, done_res,
                                   // ack_ok, timed_out, read_data[14:7], zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    i2cm_pkg::cfg_t cfg;
    i2cm_pkg::res_t res_next;
    logic           accept;

    i2cm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2cm_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .mode       (s_tuser),
        .write_data (s_tdata[7:0]),
        .ack_level  (s_tdata[8]),
        .sda_sample (s_tdata[9]),
        .cfg        (cfg),
        .res_next   (res_next)
    );

    i2cm_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .accept   (accept),
        .res_next (res_next),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
